// ===== rtl/core/rms_pkg.sv =====
// ----------------------------------------------------------------------------
// rms_pkg
// Shared types and codes for the robot motion supervisor.
// ----------------------------------------------------------------------------
package rms_pkg;

	localparam int unsigned MV_W   = 16;
	localparam int unsigned MODE_W = 4;
	localparam int unsigned IDX_W  = 2;

	// mode codes
	localparam logic [MODE_W-1:0] M_INIT     = 4'd0;
	localparam logic [MODE_W-1:0] M_CALIB    = 4'd1;
	localparam logic [MODE_W-1:0] M_IDLE     = 4'd2;
	localparam logic [MODE_W-1:0] M_NORMAL   = 4'd3;
	localparam logic [MODE_W-1:0] M_OFFGND   = 4'd4;
	localparam logic [MODE_W-1:0] M_TEST     = 4'd5;
	localparam logic [MODE_W-1:0] M_LOWBAT   = 4'd6;
	localparam logic [MODE_W-1:0] M_FALLEN   = 4'd7;
	localparam logic [MODE_W-1:0] M_ESTOP    = 4'd8;
	localparam logic [MODE_W-1:0] M_FAULT    = 4'd9;
	localparam logic [MODE_W-1:0] M_SHUTDOWN = 4'd10;

	// register indexes
	localparam logic [IDX_W-1:0] REG_EMPTY  = 2'd0;
	localparam logic [IDX_W-1:0] REG_WARN   = 2'd1;
	localparam logic [IDX_W-1:0] REG_MARGIN = 2'd2;

	// register reset values
	localparam logic [MV_W-1:0] EMPTY_RST  = 16'd0;
	localparam logic [MV_W-1:0] WARN_RST   = 16'd0;
	localparam logic [MV_W-1:0] MARGIN_RST = 16'd300;

	typedef struct packed {
		logic            estop;
		logic            driver_fault;
		logic [MV_W-1:0] battery_mv;
		logic            has_fallen;
		logic            fall_recover_ready;
		logic            wheels_off_ground;
		logic            run_request;
		logic            test_request;
		logic            calibration_done;
	} tick_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              ctrl_enable;
		logic              low_battery_warning;
	} status_t;

	typedef struct packed {
		logic [MV_W-1:0] empty_threshold_mv;
		logic [MV_W-1:0] warn_threshold_mv;
		logic [MV_W-1:0] release_margin_mv;
	} cfg_t;

endpackage

// ===== rtl/core/rms_in_if.sv =====
// ----------------------------------------------------------------------------
// rms_in_if
// Tick channel: valid/ready with the evaluation flags and battery voltage.
// ----------------------------------------------------------------------------
interface rms_in_if;
	logic                    valid;
	logic                    ready;
	logic                    estop;
	logic                    driver_fault;
	logic [rms_pkg::MV_W-1:0] battery_mv;
	logic                    has_fallen;
	logic                    fall_recover_ready;
	logic                    wheels_off_ground;
	logic                    run_request;
	logic                    test_request;
	logic                    calibration_done;

	modport source (
		output valid, estop, driver_fault, battery_mv, has_fallen, fall_recover_ready,
		       wheels_off_ground, run_request, test_request, calibration_done,
		input  ready
	);
	modport sink (
		input  valid, estop, driver_fault, battery_mv, has_fallen, fall_recover_ready,
		       wheels_off_ground, run_request, test_request, calibration_done,
		output ready
	);
endinterface

// ===== rtl/core/rms_out_if.sv =====
// ----------------------------------------------------------------------------
// rms_out_if
// Status channel: valid/ready with the new mode and its flags.
// ----------------------------------------------------------------------------
interface rms_out_if;
	logic                      valid;
	logic                      ready;
	logic [rms_pkg::MODE_W-1:0] mode;
	logic                      ctrl_enable;
	logic                      low_battery_warning;

	modport source (
		output valid, mode, ctrl_enable, low_battery_warning,
		input  ready
	);
	modport sink (
		input  valid, mode, ctrl_enable, low_battery_warning,
		output ready
	);
endinterface

// ===== rtl/core/rms_cfg.sv =====
// ----------------------------------------------------------------------------
// rms_cfg
// Threshold registers behind the plain write port.
// ----------------------------------------------------------------------------
module rms_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [rms_pkg::IDX_W-1:0]   wr_index,
	input  logic [rms_pkg::MV_W-1:0]    wr_data,
	output rms_pkg::cfg_t               cfg
);

	rms_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.empty_threshold_mv <= rms_pkg::EMPTY_RST;
			cfg_q.warn_threshold_mv  <= rms_pkg::WARN_RST;
			cfg_q.release_margin_mv  <= rms_pkg::MARGIN_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				rms_pkg::REG_EMPTY:  cfg_q.empty_threshold_mv <= wr_data;
				rms_pkg::REG_WARN:   cfg_q.warn_threshold_mv  <= wr_data;
				rms_pkg::REG_MARGIN: cfg_q.release_margin_mv  <= wr_data;
				default: ; // unused index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/rms_decide.sv =====
// ----------------------------------------------------------------------------
// rms_decide
// Priority mode decision for one tick against the stored mode.
// ----------------------------------------------------------------------------
module rms_decide (
	input  rms_pkg::tick_t                tick,
	input  logic [rms_pkg::MODE_W-1:0]    cur_mode,
	input  rms_pkg::cfg_t                 cfg,
	output rms_pkg::status_t              res
);

	logic                      at_empty;
	logic                      at_warn;
	logic [rms_pkg::MV_W:0]    release_lvl;
	logic                      below_release;

	assign at_empty      = tick.battery_mv <= cfg.empty_threshold_mv;
	assign at_warn       = tick.battery_mv <= cfg.warn_threshold_mv;
	// 17-bit sum, never wraps
	assign release_lvl   = {1'b0, cfg.warn_threshold_mv} + {1'b0, cfg.release_margin_mv};
	assign below_release = {1'b0, tick.battery_mv} < release_lvl;

	always_comb begin
		res = '{mode: rms_pkg::M_FAULT, ctrl_enable: 1'b0, low_battery_warning: 1'b0};
		if (tick.estop) begin
			res.mode = rms_pkg::M_ESTOP;
		end else if (cur_mode == rms_pkg::M_ESTOP) begin
			res.mode = rms_pkg::M_IDLE;
		end else if (tick.driver_fault) begin
			res.mode = rms_pkg::M_FAULT;
		end else if (cur_mode == rms_pkg::M_FAULT) begin
			res.mode = rms_pkg::M_CALIB;
		end else if (at_empty) begin
			res.mode = rms_pkg::M_SHUTDOWN;
		end else if (tick.has_fallen) begin
			res.mode = rms_pkg::M_FALLEN;
		end else if (cur_mode == rms_pkg::M_FALLEN && tick.fall_recover_ready) begin
			res.mode = rms_pkg::M_CALIB;
		end else if (tick.wheels_off_ground) begin
			res.mode = rms_pkg::M_OFFGND;
		end else if (cur_mode == rms_pkg::M_OFFGND) begin
			res.mode        = tick.run_request ? rms_pkg::M_NORMAL : rms_pkg::M_IDLE;
			res.ctrl_enable = tick.run_request;
		end else if (at_warn || (cur_mode == rms_pkg::M_LOWBAT && below_release)) begin
			res.mode                = rms_pkg::M_LOWBAT;
			res.ctrl_enable         = 1'b1;
			res.low_battery_warning = 1'b1;
		end else begin
			unique case (cur_mode) inside
				rms_pkg::M_INIT: begin
					res.mode        = rms_pkg::M_CALIB;
					res.ctrl_enable = 1'b1;
				end
				rms_pkg::M_CALIB: begin
					res.mode        = tick.calibration_done ? rms_pkg::M_IDLE
					                                        : rms_pkg::M_CALIB;
					res.ctrl_enable = !tick.calibration_done;
				end
				rms_pkg::M_IDLE: begin
					if (tick.test_request) begin
						res.mode        = rms_pkg::M_TEST;
						res.ctrl_enable = 1'b1;
					end else if (tick.run_request) begin
						res.mode        = rms_pkg::M_NORMAL;
						res.ctrl_enable = 1'b1;
					end else begin
						res.mode = rms_pkg::M_IDLE;
					end
				end
				rms_pkg::M_NORMAL: begin
					if (tick.test_request) begin
						res.mode        = rms_pkg::M_TEST;
						res.ctrl_enable = 1'b1;
					end else if (!tick.run_request) begin
						res.mode = rms_pkg::M_IDLE;
					end else begin
						res.mode        = rms_pkg::M_NORMAL;
						res.ctrl_enable = 1'b1;
					end
				end
				rms_pkg::M_TEST: begin
					res.mode        = tick.test_request ? rms_pkg::M_TEST : rms_pkg::M_IDLE;
					res.ctrl_enable = tick.test_request;
				end
				rms_pkg::M_OFFGND, rms_pkg::M_FALLEN, rms_pkg::M_ESTOP,
				rms_pkg::M_FAULT, rms_pkg::M_SHUTDOWN: begin
					res.mode = cur_mode;
				end
				rms_pkg::M_LOWBAT: begin
					// held once released; only higher-priority events leave
					res.mode                = rms_pkg::M_LOWBAT;
					res.ctrl_enable         = 1'b1;
					res.low_battery_warning = 1'b1;
				end
				default: begin
					res.mode = rms_pkg::M_FAULT;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/robot_motion_supervisor_fsm.sv =====
// ----------------------------------------------------------------------------
// robot_motion_supervisor_fsm
// Supervisory mode machine for a balancing robot: one status beat per tick.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  tick      in    valid/ready    estop, driver_fault, battery_mv, has_fallen,
//                                 fall_recover_ready, wheels_off_ground,
//                                 run_request, test_request, calibration_done
//  status    out   valid/ready    mode, ctrl_enable, low_battery_warning
//  wr_*      in    wr_en only     wr_index, wr_data (threshold registers)
//
//  A tick beat goes into the tick register, then its decision into the
//  status register. One beat per cycle each way unless status stalls;
//  the stored mode updates as a decided beat enters the status register.
//  arst_n clears valids, sets Init and the reset thresholds (0, 0, 300 mV).
//  A status stall holds both stages; tick is ready while the tick register
//  is empty or moving forward.
// ----------------------------------------------------------------------------
module robot_motion_supervisor_fsm (
	input  logic                        clk,
	input  logic                        arst_n,
	rms_in_if.sink                      tick,
	rms_out_if.source                   status,
	input  logic                        wr_en,
	input  logic [rms_pkg::IDX_W-1:0]   wr_index,
	input  logic [rms_pkg::MV_W-1:0]    wr_data
);

	rms_pkg::cfg_t                cfg;
	rms_pkg::tick_t               tick_s1;
	logic                         valid_s1;
	rms_pkg::status_t             res;
	rms_pkg::status_t             status_q;
	logic                         status_valid_q;
	logic [rms_pkg::MODE_W-1:0]   mode_q;
	logic                         advance;
	logic                         tick_take;

	rms_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// stage 1 moves into the status register when it is empty or drained
	assign advance   = valid_s1 && (!status_valid_q || status.ready);
	assign tick.ready = !valid_s1 || advance;
	assign tick_take = tick.valid && tick.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		if (tick_take) begin
			tick_s1.estop              <= tick.estop;
			tick_s1.driver_fault       <= tick.driver_fault;
			tick_s1.battery_mv         <= tick.battery_mv;
			tick_s1.has_fallen         <= tick.has_fallen;
			tick_s1.fall_recover_ready <= tick.fall_recover_ready;
			tick_s1.wheels_off_ground  <= tick.wheels_off_ground;
			tick_s1.run_request        <= tick.run_request;
			tick_s1.test_request       <= tick.test_request;
			tick_s1.calibration_done   <= tick.calibration_done;
		end
	end

	rms_decide u_decide (
		.tick     (tick_s1),
		.cur_mode (mode_q),
		.cfg      (cfg),
		.res      (res)
	);

	// stored mode and status valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= rms_pkg::M_INIT;
			status_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				mode_q <= res.mode;
			end
			if (advance) begin
				status_valid_q <= 1'b1;
			end else if (status.ready) begin
				status_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= res;
		end
	end

	assign status.valid               = status_valid_q;
	assign status.mode                = status_q.mode;
	assign status.ctrl_enable         = status_q.ctrl_enable;
	assign status.low_battery_warning = status_q.low_battery_warning;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------

	// the beat on offer always matches the stored mode
	a_mode_track: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid_q |-> status_q.mode == mode_q)
		else $error("status mode differs from stored mode");

	// emergency stop wins over everything
	a_estop_wins: assert property (@(posedge clk) disable iff (!arst_n)
		advance && tick_s1.estop |=> status_valid_q && status_q.mode == rms_pkg::M_ESTOP)
		else $error("estop tick did not yield EStop");

	// warning only ever comes with LowBat and control allowed
	a_warn_lowbat: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid_q && status_q.low_battery_warning |->
			status_q.mode == rms_pkg::M_LOWBAT && status_q.ctrl_enable)
		else $error("low battery warning outside LowBat");

	// stored mode only moves when a beat is decided
	a_mode_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(mode_q))
		else $error("stored mode changed without a decided beat");

endmodule

// ===== verif/rms_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rms_checker
// Watches the tick, status and register-write ports of the motion supervisor,
// tracks mode and thresholds on its own and checks every status beat in order.
// ----------------------------------------------------------------------------
module rms_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	rms_in_if                     tick,
	rms_out_if                    status,
	input  logic                  wr_en,
	input  logic [rms_pkg::IDX_W-1:0] wr_index,
	input  logic [rms_pkg::MV_W-1:0]  wr_data,
	output int                    failures,
	output int                    pending,
	output int                    checked
);

	localparam int REPORT_MAX = 10;

	rms_pkg::cfg_t                thresholds;
	logic [rms_pkg::MODE_W-1:0]   mode_now;
	rms_pkg::status_t             status_due[$];

	function automatic rms_pkg::status_t mode_status(input logic [rms_pkg::MODE_W-1:0] m,
		input logic ctl, input logic warn);
		rms_pkg::status_t s;
		s.mode                = m;
		s.ctrl_enable         = ctl;
		s.low_battery_warning = warn;
		return s;
	endfunction

	// Priority chain of one evaluation tick.
	function automatic rms_pkg::status_t supervise(input rms_pkg::tick_t t,
		input logic [rms_pkg::MODE_W-1:0] cur, input rms_pkg::cfg_t c);
		logic [rms_pkg::MV_W:0] release_mv;
		release_mv = {1'b0, c.warn_threshold_mv} + {1'b0, c.release_margin_mv};
		if (t.estop)
			return mode_status(rms_pkg::M_ESTOP, 1'b0, 1'b0);
		if (cur == rms_pkg::M_ESTOP)
			return mode_status(rms_pkg::M_IDLE, 1'b0, 1'b0);
		if (t.driver_fault)
			return mode_status(rms_pkg::M_FAULT, 1'b0, 1'b0);
		if (cur == rms_pkg::M_FAULT)
			return mode_status(rms_pkg::M_CALIB, 1'b0, 1'b0);
		if (t.battery_mv <= c.empty_threshold_mv)
			return mode_status(rms_pkg::M_SHUTDOWN, 1'b0, 1'b0);
		if (t.has_fallen)
			return mode_status(rms_pkg::M_FALLEN, 1'b0, 1'b0);
		if (cur == rms_pkg::M_FALLEN && t.fall_recover_ready)
			return mode_status(rms_pkg::M_CALIB, 1'b0, 1'b0);
		if (t.wheels_off_ground)
			return mode_status(rms_pkg::M_OFFGND, 1'b0, 1'b0);
		if (cur == rms_pkg::M_OFFGND) begin
			if (t.run_request) return mode_status(rms_pkg::M_NORMAL, 1'b1, 1'b0);
			return mode_status(rms_pkg::M_IDLE, 1'b0, 1'b0);
		end
		if (t.battery_mv <= c.warn_threshold_mv)
			return mode_status(rms_pkg::M_LOWBAT, 1'b1, 1'b1);
		// hysteresis: stay low until voltage clears warn + margin (17-bit sum)
		if (cur == rms_pkg::M_LOWBAT && {1'b0, t.battery_mv} < release_mv)
			return mode_status(rms_pkg::M_LOWBAT, 1'b1, 1'b1);
		case (cur) inside
			rms_pkg::M_INIT: begin
				return mode_status(rms_pkg::M_CALIB, 1'b1, 1'b0);
			end
			rms_pkg::M_CALIB: begin
				if (t.calibration_done) return mode_status(rms_pkg::M_IDLE, 1'b0, 1'b0);
				return mode_status(rms_pkg::M_CALIB, 1'b1, 1'b0);
			end
			rms_pkg::M_IDLE: begin
				if (t.test_request) return mode_status(rms_pkg::M_TEST, 1'b1, 1'b0);
				if (t.run_request)  return mode_status(rms_pkg::M_NORMAL, 1'b1, 1'b0);
				return mode_status(rms_pkg::M_IDLE, 1'b0, 1'b0);
			end
			rms_pkg::M_NORMAL: begin
				if (t.test_request) return mode_status(rms_pkg::M_TEST, 1'b1, 1'b0);
				if (!t.run_request) return mode_status(rms_pkg::M_IDLE, 1'b0, 1'b0);
				return mode_status(rms_pkg::M_NORMAL, 1'b1, 1'b0);
			end
			rms_pkg::M_TEST: begin
				if (!t.test_request) return mode_status(rms_pkg::M_IDLE, 1'b0, 1'b0);
				return mode_status(rms_pkg::M_TEST, 1'b1, 1'b0);
			end
			rms_pkg::M_OFFGND, rms_pkg::M_FALLEN, rms_pkg::M_ESTOP,
			rms_pkg::M_FAULT, rms_pkg::M_SHUTDOWN: begin
				return mode_status(cur, 1'b0, 1'b0);
			end
			// released voltage alone never leaves low battery
			rms_pkg::M_LOWBAT: begin
				return mode_status(rms_pkg::M_LOWBAT, 1'b1, 1'b1);
			end
			default: begin
				return mode_status(rms_pkg::M_FAULT, 1'b0, 1'b0);
			end
		endcase
	endfunction

	task automatic flag(input string what);
		failures++;
		if (failures <= REPORT_MAX) begin
			$display("[%0t] FAIL %s", $realtime, what);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rms_pkg::tick_t   t;
		rms_pkg::status_t got;
		rms_pkg::status_t want;
		if (!arst_n) begin
			thresholds.empty_threshold_mv <= rms_pkg::EMPTY_RST;
			thresholds.warn_threshold_mv  <= rms_pkg::WARN_RST;
			thresholds.release_margin_mv  <= rms_pkg::MARGIN_RST;
			mode_now <= rms_pkg::M_INIT;
			status_due.delete();
			pending  = 0;
			failures = 0;
			checked  = 0;
		end else begin
			// older beat leaves first
			if (status.valid && status.ready) begin
				got.mode                = status.mode;
				got.ctrl_enable         = status.ctrl_enable;
				got.low_battery_warning = status.low_battery_warning;
				checked++;
				if (status_due.size() == 0) begin
					flag($sformatf("status beat %0d with nothing due: mode %0d ctl %0b warn %0b",
						checked, got.mode, got.ctrl_enable, got.low_battery_warning));
				end else begin
					want = status_due.pop_front();
					if (got.mode !== want.mode ||
						got.ctrl_enable !== want.ctrl_enable ||
						got.low_battery_warning !== want.low_battery_warning) begin
						flag($sformatf({"status beat %0d: mode exp %0d got %0d, ",
							"ctl exp %0b got %0b, warn exp %0b got %0b"},
							checked, want.mode, got.mode, want.ctrl_enable,
							got.ctrl_enable, want.low_battery_warning,
							got.low_battery_warning));
					end
				end
			end
			if (tick.valid && tick.ready) begin
				t.estop              = tick.estop;
				t.driver_fault       = tick.driver_fault;
				t.battery_mv         = tick.battery_mv;
				t.has_fallen         = tick.has_fallen;
				t.fall_recover_ready = tick.fall_recover_ready;
				t.wheels_off_ground  = tick.wheels_off_ground;
				t.run_request        = tick.run_request;
				t.test_request       = tick.test_request;
				t.calibration_done   = tick.calibration_done;
				want = supervise(t, mode_now, thresholds);
				status_due.push_back(want);
				mode_now <= want.mode;
			end
			if (wr_en) begin
				case (wr_index)
					rms_pkg::REG_EMPTY:  thresholds.empty_threshold_mv <= wr_data;
					rms_pkg::REG_WARN:   thresholds.warn_threshold_mv  <= wr_data;
					rms_pkg::REG_MARGIN: thresholds.release_margin_mv  <= wr_data;
					default: ;
				endcase
			end
			pending = status_due.size();
		end
	end

endmodule

// ===== verif/tb_robot_motion_supervisor_fsm.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_robot_motion_supervisor_fsm
// Drives evaluation ticks and threshold writes into the motion supervisor,
// with random idling on both channels and long status stalls; the checker
// beside the block predicts every status beat and counts mismatches.
// ----------------------------------------------------------------------------
module tb_robot_motion_supervisor_fsm;

	localparam int unsigned MV_W  = rms_pkg::MV_W;
	localparam int unsigned IDX_W = rms_pkg::IDX_W;

	// write to the one index the block does not decode; must be a no-op
	localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

	localparam int ROUNDS       = 8;
	localparam int ROUND_ITEMS  = 100;
	localparam int STALL_CYCLES = 240;
	localparam int DRAIN_LIMIT  = 5000;
	localparam int TAIL_CYCLES  = 6;    // two-stage pipe, with some slack

	logic              clk;
	logic              arst_n;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_index;
	logic [MV_W-1:0]   wr_data;

	int snd_idle;    // percent of cycles the tick side holds back
	int rcv_idle;    // percent of cycles the status side holds back
	int hold_req;    // long status stall request, picked up at a falling edge
	int failures;
	int pending;
	int checked;
	int sent;
	int settings;

	rms_in_if  tick_bus ();
	rms_out_if status_bus ();

	robot_motion_supervisor_fsm u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick_bus),
		.status   (status_bus),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	rms_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick_bus),
		.status   (status_bus),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.failures (failures),
		.pending  (pending),
		.checked  (checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Status side. The decision for the next edge is made at the falling
	// edge, so knob changes made just after a rising edge never race it.
	initial begin
		int hold_left;
		bit rdy;
		status_bus.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left != 0) begin
				// long hold-off: block fills and must stall the tick side
				rdy = 1'b0;
				hold_left--;
			end else begin
				rdy = ($urandom_range(0, 99) >= rcv_idle);
			end
			@(posedge clk);
			status_bus.ready <= rdy;
		end
	end

	function automatic rms_pkg::tick_t tick_of(input int e, input int f, input int mv,
		input int fal, input int rec, input int off, input int run, input int tst,
		input int cal);
		rms_pkg::tick_t t;
		t.estop              = e[0];
		t.driver_fault       = f[0];
		t.battery_mv         = MV_W'(mv);
		t.has_fallen         = fal[0];
		t.fall_recover_ready = rec[0];
		t.wheels_off_ground  = off[0];
		t.run_request        = run[0];
		t.test_request       = tst[0];
		t.calibration_done   = cal[0];
		return t;
	endfunction

	function automatic logic [MV_W-1:0] clamp_mv(input int v);
		if (v < 0)     return '0;
		if (v > 65535) return '1;
		return MV_W'(v);
	endfunction

	// All driving tasks are entered just after a rising edge and return
	// just after one, so each signal gets one assignment per step.
	task automatic send_tick(input rms_pkg::tick_t t);
		bit took;
		while ($urandom_range(0, 99) < snd_idle) begin
			tick_bus.valid <= 1'b0;
			@(posedge clk);
		end
		tick_bus.valid              <= 1'b1;
		tick_bus.estop              <= t.estop;
		tick_bus.driver_fault       <= t.driver_fault;
		tick_bus.battery_mv         <= t.battery_mv;
		tick_bus.has_fallen         <= t.has_fallen;
		tick_bus.fall_recover_ready <= t.fall_recover_ready;
		tick_bus.wheels_off_ground  <= t.wheels_off_ground;
		tick_bus.run_request        <= t.run_request;
		tick_bus.test_request       <= t.test_request;
		tick_bus.calibration_done   <= t.calibration_done;
		// ready is settled by the falling edge and holds to the next rise
		do begin
			@(negedge clk);
			took = tick_bus.ready;
			@(posedge clk);
		end while (!took);
		sent++;
	endtask

	// Threshold writes go back to back; the enable drops once at the end.
	task automatic apply_settings(input rms_pkg::cfg_t c, input bit poke_spare);
		wr_en    <= 1'b1;
		wr_index <= rms_pkg::REG_EMPTY;
		wr_data  <= c.empty_threshold_mv;
		@(posedge clk);
		wr_index <= rms_pkg::REG_WARN;
		wr_data  <= c.warn_threshold_mv;
		@(posedge clk);
		wr_index <= rms_pkg::REG_MARGIN;
		wr_data  <= c.release_margin_mv;
		@(posedge clk);
		if (poke_spare) begin
			wr_index <= REG_SPARE;
			wr_data  <= MV_W'($urandom);
			@(posedge clk);
		end
		wr_en <= 1'b0;
		settings++;
	endtask

	// Drop valid, wait for every due status beat, then let the pipe empty.
	task automatic settle();
		int spins;
		spins = 0;
		tick_bus.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0 && spins < DRAIN_LIMIT) begin
			@(negedge clk);
			spins++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	initial begin
		rms_pkg::cfg_t  cfg;
		rms_pkg::tick_t t;
		logic [31:0]    noise;
		int             e;
		int             w;
		int             rel;

		arst_n   = 1'b0;
		wr_en    = 1'b0;
		wr_index = rms_pkg::REG_EMPTY;
		wr_data  = '0;
		tick_bus.valid              = 1'b0;
		tick_bus.estop              = 1'b0;
		tick_bus.driver_fault       = 1'b0;
		tick_bus.battery_mv         = '0;
		tick_bus.has_fallen         = 1'b0;
		tick_bus.fall_recover_ready = 1'b0;
		tick_bus.wheels_off_ground  = 1'b0;
		tick_bus.run_request        = 1'b0;
		tick_bus.test_request       = 1'b0;
		tick_bus.calibration_done   = 1'b0;
		snd_idle = 18;
		rcv_idle = 77;
		hold_req = 0;
		sent     = 0;
		settings = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed walk: empty 1000, warn 3000, release at 3300 mV ----
		cfg.empty_threshold_mv = 16'd1000;
		cfg.warn_threshold_mv  = 16'd3000;
		cfg.release_margin_mv  = 16'd300;
		apply_settings(cfg, 1'b1);
		send_tick(tick_of(0, 0, 5000, 0, 0, 0, 0, 0, 0));     // Init -> Calibrating
		send_tick(tick_of(0, 0, 5000, 0, 0, 0, 0, 0, 1));     // calibrated -> Idle
		send_tick(tick_of(0, 0, 5000, 0, 0, 0, 1, 0, 0));     // run -> Normal
		send_tick(tick_of(0, 0, 5000, 0, 0, 0, 1, 1, 0));     // test wins over run
		send_tick(tick_of(0, 0, 5000, 0, 0, 0, 0, 0, 0));     // test dropped -> Idle
		send_tick(tick_of(0, 0, 5000, 0, 0, 0, 1, 0, 0));     // Normal again
		send_tick(tick_of(0, 0, 5000, 0, 0, 0, 0, 0, 0));     // run dropped -> Idle
		send_tick(tick_of(0, 0, 5000, 0, 0, 1, 0, 0, 0));     // lifted
		send_tick(tick_of(0, 0, 5000, 0, 0, 0, 1, 0, 0));     // back down, running
		send_tick(tick_of(0, 0, 5000, 0, 0, 1, 1, 0, 0));     // lifted while running
		send_tick(tick_of(0, 0, 5000, 0, 0, 0, 0, 0, 0));     // back down, no run -> Idle
		send_tick(tick_of(0, 0, 5000, 1, 0, 0, 0, 0, 0));     // fallen
		send_tick(tick_of(0, 0, 5000, 0, 0, 0, 1, 0, 0));     // no recovery yet, stays
		send_tick(tick_of(0, 0, 5000, 0, 1, 0, 0, 0, 0));     // recovered -> Calibrating
		send_tick(tick_of(0, 0, 3000, 0, 0, 0, 0, 0, 0));     // at warn -> low battery
		send_tick(tick_of(0, 0, 3299, 0, 0, 0, 0, 0, 0));     // just under release
		send_tick(tick_of(0, 0, 65535, 0, 0, 0, 1, 0, 0));    // released yet held in LowBat
		send_tick(tick_of(0, 0, 1000, 0, 0, 0, 0, 0, 0));     // at empty -> Shutdown
		send_tick(tick_of(0, 0, 5000, 0, 0, 0, 1, 0, 0));     // recovered voltage, held
		send_tick(tick_of(0, 0, 2000, 0, 0, 0, 0, 0, 0));     // Shutdown left via LowBat
		send_tick(tick_of(1, 1, 0, 1, 1, 1, 1, 1, 1));        // estop beats everything
		send_tick(tick_of(0, 0, 5000, 0, 0, 0, 0, 0, 0));     // EStop -> Idle
		send_tick(tick_of(0, 1, 5000, 0, 0, 0, 0, 0, 0));     // driver fault
		send_tick(tick_of(0, 0, 5000, 0, 0, 0, 0, 0, 0));     // Fault -> Calibrating
		send_tick(tick_of(0, 0, 0, 0, 0, 0, 0, 0, 0));        // zero volts -> Shutdown

		// ---- random rounds, each under its own thresholds, in three idle mixes ----
		for (int r = 0; r < ROUNDS; r++) begin
			settle();
			if (r < 3) begin
				snd_idle = 18;
				rcv_idle = 77;
			end else if (r < 6) begin
				snd_idle = 77;
				rcv_idle = 18;
			end else begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			case (r)
				0: begin
					cfg.empty_threshold_mv = 16'd6000;
					cfg.warn_threshold_mv  = 16'd7000;
					cfg.release_margin_mv  = 16'd500;
				end
				1: begin
					// everything zero: no hysteresis at all
					cfg.empty_threshold_mv = 16'd0;
					cfg.warn_threshold_mv  = 16'd0;
					cfg.release_margin_mv  = 16'd0;
				end
				2: begin
					// every voltage is empty; only estop/fault get out
					cfg.empty_threshold_mv = 16'hFFFF;
					cfg.warn_threshold_mv  = 16'd40000;
					cfg.release_margin_mv  = 16'd300;
				end
				3: begin
					// release point needs the 17th bit
					cfg.empty_threshold_mv = 16'd1000;
					cfg.warn_threshold_mv  = 16'hFFFF;
					cfg.release_margin_mv  = 16'hFFFF;
				end
				7: begin
					cfg.empty_threshold_mv = MV_W'($urandom);
					cfg.warn_threshold_mv  = MV_W'($urandom);
					cfg.release_margin_mv  = MV_W'($urandom);
				end
				default: begin
					e = int'($urandom_range(0, 20000));
					w = e + int'($urandom_range(0, 20000));
					cfg.empty_threshold_mv = MV_W'(e);
					cfg.warn_threshold_mv  = MV_W'(w);
					cfg.release_margin_mv  = MV_W'($urandom_range(0, 3000));
				end
			endcase
			apply_settings(cfg, r == 4);
			if (r == 1 || r == 6) begin
				hold_req = STALL_CYCLES;
			end
			rel = int'(cfg.warn_threshold_mv) + int'(cfg.release_margin_mv);
			repeat (ROUND_ITEMS) begin
				noise = $urandom;
				t = noise[$bits(rms_pkg::tick_t)-1:0];
				// nine in ten ticks look like real operation: rare hazards,
				// operator commands toggling, voltage mostly healthy
				if ($urandom_range(0, 9) != 0) begin
					t.estop              = ($urandom_range(0, 99) < 3);
					t.driver_fault       = ($urandom_range(0, 99) < 3);
					t.has_fallen         = ($urandom_range(0, 99) < 6);
					t.fall_recover_ready = ($urandom_range(0, 99) < 50);
					t.wheels_off_ground  = ($urandom_range(0, 99) < 6);
					t.run_request        = ($urandom_range(0, 99) < 55);
					t.test_request       = ($urandom_range(0, 99) < 30);
					t.calibration_done   = ($urandom_range(0, 99) < 50);
					case ($urandom_range(0, 11))
						0: t.battery_mv = '0;
						1: t.battery_mv = '1;
						2: t.battery_mv = clamp_mv(int'(cfg.empty_threshold_mv)
							+ int'($urandom_range(0, 4)) - 2);
						3: t.battery_mv = clamp_mv(int'(cfg.warn_threshold_mv)
							+ int'($urandom_range(0, 4)) - 2);
						4: t.battery_mv = clamp_mv(rel + int'($urandom_range(0, 4)) - 2);
						5: ;    // keep the raw random voltage
						default: begin
							if (rel < 65535) begin
								t.battery_mv = clamp_mv(int'($urandom_range(rel + 1, 65535)));
							end
						end
					endcase
				end
				send_tick(t);
			end
		end

		settle();
		$display("covered %0d ticks, %0d status beats checked, %0d threshold settings",
			sent, checked, settings);
		$display("idle mixes 18/77, 77/18 and none on tick/status, two long status stalls");
		if (pending != 0) begin
			$display("%0d status beats never arrived", pending);
		end
		if (failures == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/rms_pkg.sv
rtl/core/rms_in_if.sv
rtl/core/rms_out_if.sv
rtl/core/rms_cfg.sv
rtl/core/rms_decide.sv
rtl/core/robot_motion_supervisor_fsm.sv
verif/rms_checker.sv
verif/tb_robot_motion_supervisor_fsm.sv
